// ===== hdl/acff_pkg.sv =====
// Shared types, codes and fixed-point helpers of the angle charge-flux force block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package acff_pkg;

    // Width of the stored Q16.16 products qa, qc and the bend weight p
    localparam int QW = 49;

    // Operation codes of the shared iterative arithmetic unit
    localparam logic [1:0] AU_MUL  = 2'd0;
    localparam logic [1:0] AU_DIV  = 2'd1;
    localparam logic [1:0] AU_SQRT = 2'd2;

    // Status codes of a result
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DEG = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] ab_x;
        logic signed [31:0] ab_y;
        logic signed [31:0] ab_z;
        logic signed [31:0] cb_x;
        logic signed [31:0] cb_y;
        logic signed [31:0] cb_z;
        logic signed [31:0] dpot_a;
        logic signed [31:0] dpot_c;
        logic signed [31:0] angle_flux_a;
        logic signed [31:0] angle_flux_c;
        logic signed [31:0] stretch_flux_a;
        logic signed [31:0] stretch_flux_c;
    } t_acff_in;

    typedef struct packed {
        logic signed [31:0] fa_x;
        logic signed [31:0] fa_y;
        logic signed [31:0] fa_z;
        logic signed [31:0] fb_x;
        logic signed [31:0] fb_y;
        logic signed [31:0] fb_z;
        logic signed [31:0] fc_x;
        logic signed [31:0] fc_y;
        logic signed [31:0] fc_z;
        logic [1:0]         status;
    } t_acff_out;

    // One prepared angle term, passed from the front to the back
    typedef struct packed {
        logic signed [31:0]   ux;
        logic signed [31:0]   uy;
        logic signed [31:0]   uz;
        logic signed [31:0]   vx;
        logic signed [31:0]   vy;
        logic signed [31:0]   vz;
        logic [63:0]          a2;
        logic [63:0]          c2;
        logic signed [QW-1:0] qa;
        logic signed [QW-1:0] qc;
        logic signed [QW-1:0] p;
    } t_acff_job;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic        sh30;
    } t_au_req;

    typedef struct packed {
        logic        done;
        logic        dsat;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_au_rsp;

    typedef struct packed {
        logic              sat;
        logic signed [63:0] val;
    } t_sv64;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } t_su64;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_sv32;

    function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        logic [63:0] r;
        r = a[63] ? 64'(-a) : 64'(a);
        return r;
    endfunction

    // Magnitude and sign back to a signed value, clamped
    function automatic t_sv64 from_mag(input logic [63:0] m, input logic neg);
        t_sv64 r;
        r.sat = 1'b0;
        if (neg) begin
            if (m > 64'h8000_0000_0000_0000) begin
                r.sat = 1'b1;
                r.val = S64_MIN;
            end else begin
                r.val = -$signed(m);
            end
        end else if (m[63]) begin
            r.sat = 1'b1;
            r.val = S64_MAX;
        end else begin
            r.val = $signed(m);
        end
        return r;
    endfunction

    // Product magnitude shifted down with truncation, signed and clamped
    function automatic t_sv64 mul_post(input logic [127:0] prod, input logic sh30,
                                       input logic neg);
        logic [127:0] s;
        t_sv64        r;
        s = sh30 ? (prod >> 30) : (prod >> 16);
        if (s[127:64] != 64'd0) begin
            r.sat = 1'b1;
            r.val = neg ? S64_MIN : S64_MAX;
        end else begin
            r = from_mag(s[63:0], neg);
        end
        return r;
    endfunction

    function automatic t_sv64 add_sat(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        t_sv64 r;
        r.val = a + b;
        r.sat = (a[63] == b[63]) && (r.val[63] != a[63]);
        if (r.sat) r.val = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic t_sv64 sub_sat(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        t_sv64 r;
        r.val = a - b;
        r.sat = (a[63] != b[63]) && (r.val[63] != a[63]);
        if (r.sat) r.val = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    // Add the square of c to an unsigned accumulator, clamped
    function automatic t_su64 usq_add(input logic [63:0] acc, input logic signed [63:0] c);
        logic [63:0] m;
        logic [63:0] s;
        logic [64:0] sum;
        t_su64       r;
        m   = mag64(c);
        s   = 64'(m[31:0]) * 64'(m[31:0]);
        sum = {1'b0, acc} + {1'b0, s};
        if (m[63:32] != 32'd0 || sum[64]) begin
            r.sat = 1'b1;
            r.val = '1;
        end else begin
            r.sat = 1'b0;
            r.val = sum[63:0];
        end
        return r;
    endfunction

    function automatic t_sv32 out32(input logic signed [63:0] x);
        t_sv32 r;
        r.sat = 1'b0;
        r.val = x[31:0];
        if (x[63:31] != {33{x[63]}}) begin
            r.sat = 1'b1;
            r.val = x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Divide by 2^16 with truncation toward zero
    function automatic logic signed [QW-1:0] tdiv16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = (x + (x[63] ? 64'sd65535 : 64'sd0)) >>> 16;
        return t[QW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/angle_charge_flux_force_top.sv =====
// Top level of the angle charge-flux force block: front, queue, back and shared unit.
// Depends on acff_pkg, acff_front, acff_fifo, acff_alu and acff_back.
//
// One angle term in, one force result out, on valid/stall channels. The front takes
// a term and forms the exact squares and flux products; a two-entry queue
// lets it keep accepting while the back works. The back runs every square root,
// division and wide multiply on one shared bit-serial unit (32 steps per root, 64 per
// divide or multiply); a term with a zero length or collinear bonds ends after the
// failing square root. The result waits in an output register, so the back starts the
// next term while the previous result is still stalled.
`default_nettype none
module angle_charge_flux_force_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire acff_pkg::t_acff_in   i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output acff_pkg::t_acff_out       o_data
);

    logic                push, full, qvalid, pop;
    acff_pkg::t_acff_job fjob, qjob;
    acff_pkg::t_au_req   au_req;
    acff_pkg::t_au_rsp   au_rsp;

    acff_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .o_job   (fjob),
        .i_full  (full)
    );

    acff_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fjob),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (qjob)
    );

    acff_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (au_req),
        .o_rsp   (au_rsp)
    );

    acff_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .o_pop    (pop),
        .i_job    (qjob),
        .o_req    (au_req),
        .i_rsp    (au_rsp),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule
`default_nettype wire

// ===== hdl/acff_front.sv =====
// Front part: accepts angle terms and forms the exact squares and flux products.
// Depends on acff_pkg.
`default_nettype none
module acff_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire acff_pkg::t_acff_in   i_data,
    output logic                      o_push,
    output acff_pkg::t_acff_job       o_job,
    input  wire logic                 i_full
);

    logic               r_f_valid;
    logic signed [31:0] r_u [3];
    logic signed [31:0] r_v [3];
    logic signed [63:0] r_sq [6];
    logic signed [63:0] r_pqa, r_pqc, r_ppa, r_ppc;
    logic               accept;

    // Hold the stage while the queue is full
    assign o_stall = r_f_valid & i_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_f_valid & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    // Capture coordinates and exact 32x32 products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_u[0]  <= i_data.ab_x;
            r_u[1]  <= i_data.ab_y;
            r_u[2]  <= i_data.ab_z;
            r_v[0]  <= i_data.cb_x;
            r_v[1]  <= i_data.cb_y;
            r_v[2]  <= i_data.cb_z;
            r_sq[0] <= acff_pkg::smul32(i_data.ab_x, i_data.ab_x);
            r_sq[1] <= acff_pkg::smul32(i_data.ab_y, i_data.ab_y);
            r_sq[2] <= acff_pkg::smul32(i_data.ab_z, i_data.ab_z);
            r_sq[3] <= acff_pkg::smul32(i_data.cb_x, i_data.cb_x);
            r_sq[4] <= acff_pkg::smul32(i_data.cb_y, i_data.cb_y);
            r_sq[5] <= acff_pkg::smul32(i_data.cb_z, i_data.cb_z);
            r_pqa   <= acff_pkg::smul32(i_data.stretch_flux_a, i_data.dpot_a);
            r_pqc   <= acff_pkg::smul32(i_data.stretch_flux_c, i_data.dpot_c);
            r_ppa   <= acff_pkg::smul32(i_data.dpot_a, i_data.angle_flux_a);
            r_ppc   <= acff_pkg::smul32(i_data.dpot_c, i_data.angle_flux_c);
        end
    end

    // Sum squared lengths and scale products to Q16.16
    always_comb begin
        o_job.ux = r_u[0];
        o_job.uy = r_u[1];
        o_job.uz = r_u[2];
        o_job.vx = r_v[0];
        o_job.vy = r_v[1];
        o_job.vz = r_v[2];
        o_job.a2 = 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        o_job.c2 = 64'(r_sq[3]) + 64'(r_sq[4]) + 64'(r_sq[5]);
        o_job.qa = acff_pkg::tdiv16(r_pqa);
        o_job.qc = acff_pkg::tdiv16(r_pqc);
        o_job.p  = acff_pkg::QW'(64'(acff_pkg::tdiv16(r_ppa)) + 64'(acff_pkg::tdiv16(r_ppc)));
    end

endmodule
`default_nettype wire

// ===== hdl/acff_fifo.sv =====
// Two-entry queue of prepared angle terms between the front and the back.
// Depends on acff_pkg.
`default_nettype none
module acff_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire acff_pkg::t_acff_job  i_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output acff_pkg::t_acff_job       o_data
);

    acff_pkg::t_acff_job r_mem [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== hdl/acff_alu.sv =====
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, square root.
// Depends on acff_pkg.
`default_nettype none
module acff_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acff_pkg::t_au_req i_req,
    output acff_pkg::t_au_rsp      o_rsp
);

    localparam logic [6:0] MUL_STEPS  = 7'd64;
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [1:0]  r_op;
    logic [63:0] r_hi, r_lo, r_m;
    logic        r_dsat;
    logic [63:0] hi0, lo0;
    logic [64:0] msum;
    logic [63:0] dh2;
    logic [63:0] rb;

    always_comb begin
        hi0  = i_req.sh30 ? (i_req.a >> 34) : (i_req.a >> 48);
        lo0  = i_req.sh30 ? (i_req.a << 30) : (i_req.a << 16);
        msum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_m} : 65'd0);
        dh2  = {r_hi[62:0], r_lo[63]};
        rb   = r_lo + r_m;
    end

    assign o_rsp.done = r_busy && (r_cnt == 7'd0);
    assign o_rsp.dsat = r_dsat;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_req.start && !r_busy) begin
            // Load operands for a new operation
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_dsat <= 1'b0;
            unique case (i_req.op)
                acff_pkg::AU_MUL: begin
                    r_hi  <= 64'd0;
                    r_lo  <= i_req.b;
                    r_m   <= i_req.a;
                    r_cnt <= MUL_STEPS;
                end
                acff_pkg::AU_DIV: begin
                    r_hi <= hi0;
                    r_lo <= lo0;
                    r_m  <= i_req.b;
                    if (hi0 >= i_req.b) begin
                        r_dsat <= 1'b1;
                        r_cnt  <= 7'd0;
                    end else begin
                        r_cnt <= DIV_STEPS;
                    end
                end
                default: begin
                    r_hi  <= i_req.a;
                    r_lo  <= 64'd0;
                    r_m   <= 64'h4000_0000_0000_0000;
                    r_cnt <= SQRT_STEPS;
                end
            endcase
        end else if (r_busy) begin
            if (r_cnt == 7'd0) begin
                r_busy <= 1'b0;
            end else begin
                // One step of the running operation
                r_cnt <= r_cnt - 7'd1;
                unique case (r_op)
                    acff_pkg::AU_MUL: begin
                        r_hi <= msum[64:1];
                        r_lo <= {msum[0], r_lo[63:1]};
                    end
                    acff_pkg::AU_DIV: begin
                        if (r_hi[63] || dh2 >= r_m) begin
                            r_hi <= dh2 - r_m;
                            r_lo <= {r_lo[62:0], 1'b1};
                        end else begin
                            r_hi <= dh2;
                            r_lo <= {r_lo[62:0], 1'b0};
                        end
                    end
                    default: begin
                        if (r_hi >= rb) begin
                            r_hi <= r_hi - rb;
                            r_lo <= (r_lo >> 1) + r_m;
                        end else begin
                            r_lo <= r_lo >> 1;
                        end
                        r_m <= r_m >> 2;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/acff_back.sv =====
// Back part: sequences the force computation of one angle term on the shared unit.
// Depends on acff_pkg; drives acff_alu and the output register.
`default_nettype none
module acff_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_qvalid,
    output logic                      o_pop,
    input  wire acff_pkg::t_acff_job  i_job,
    output acff_pkg::t_au_req         o_req,
    input  wire acff_pkg::t_au_rsp    i_rsp,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output acff_pkg::t_acff_out       o_data
);

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_SQA  = 5'd1;
    localparam logic [4:0] PH_SQC  = 5'd2;
    localparam logic [4:0] PH_UH   = 5'd3;
    localparam logic [4:0] PH_VH   = 5'd4;
    localparam logic [4:0] PH_COS  = 5'd5;
    localparam logic [4:0] PH_CR0  = 5'd6;
    localparam logic [4:0] PH_CR1  = 5'd7;
    localparam logic [4:0] PH_S2   = 5'd8;
    localparam logic [4:0] PH_SN   = 5'd9;
    localparam logic [4:0] PH_KA   = 5'd10;
    localparam logic [4:0] PH_KC   = 5'd11;
    localparam logic [4:0] PH_WA   = 5'd12;
    localparam logic [4:0] PH_TA   = 5'd13;
    localparam logic [4:0] PH_MQC  = 5'd14;
    localparam logic [4:0] PH_FA   = 5'd15;
    localparam logic [4:0] PH_WC   = 5'd16;
    localparam logic [4:0] PH_TC   = 5'd17;
    localparam logic [4:0] PH_MQA  = 5'd18;
    localparam logic [4:0] PH_FC   = 5'd19;
    localparam logic [4:0] PH_FB   = 5'd20;
    localparam logic [4:0] PH_OUT  = 5'd21;

    logic [4:0]                  r_ph;
    logic [1:0]                  r_k;
    logic                        r_iss;
    logic signed [31:0]          r_u [3];
    logic signed [31:0]          r_v [3];
    logic signed [acff_pkg::QW-1:0] r_qa, r_qc, r_p;
    logic [63:0]                 r_a2, r_c2, r_s2;
    logic [31:0]                 r_ra, r_rc, r_sn;
    logic signed [63:0]          r_uh [3];
    logic signed [63:0]          r_vh [3];
    logic signed [63:0]          r_fa [3];
    logic signed [63:0]          r_fc [3];
    logic signed [63:0]          r_fb [3];
    logic signed [63:0]          r_cos, r_t, r_w, r_ta, r_tc, r_ka, r_kc;
    logic                        r_sat, r_deg;
    logic                        r_ov;
    acff_pkg::t_acff_out         r_od;

    logic               use_au;
    logic [1:0]         op;
    logic signed [63:0] sa, sb;
    logic [63:0]        ua, ud;
    logic               sh30, neg;
    logic [1:0]         j1, j2;
    logic [31:0]        root;
    acff_pkg::t_sv64    mr, dr, fs, fba, fbs;
    acff_pkg::t_su64    us;
    acff_pkg::t_sv32    o32 [9];
    logic               out_free, any_clamp;
    acff_pkg::t_acff_out nd;

    assign j1 = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
    assign j2 = (r_k == 2'd0) ? 2'd2 : r_k - 2'd1;

    // Select the operation and operands of the current phase
    always_comb begin
        use_au = 1'b1;
        op     = acff_pkg::AU_MUL;
        sa     = '0;
        sb     = '0;
        ua     = '0;
        ud     = '0;
        sh30   = 1'b1;
        unique case (r_ph)
            PH_SQA:  begin op = acff_pkg::AU_SQRT; ua = r_a2; end
            PH_SQC:  begin op = acff_pkg::AU_SQRT; ua = r_c2; end
            PH_UH:   begin op = acff_pkg::AU_DIV; sa = 64'(r_u[r_k]); ud = 64'(r_ra); end
            PH_VH:   begin op = acff_pkg::AU_DIV; sa = 64'(r_v[r_k]); ud = 64'(r_rc); end
            PH_COS:  begin sa = r_uh[r_k]; sb = r_vh[r_k]; end
            PH_CR0:  begin sa = r_uh[j1]; sb = r_vh[j2]; end
            PH_CR1:  begin sa = r_uh[j2]; sb = r_vh[j1]; end
            PH_SN:   begin op = acff_pkg::AU_SQRT; ua = r_s2; end
            PH_KA:   begin
                op = acff_pkg::AU_DIV; sa = 64'(r_p); ud = 64'(r_ra); sh30 = 1'b0;
            end
            PH_KC:   begin
                op = acff_pkg::AU_DIV; sa = 64'(r_p); ud = 64'(r_rc); sh30 = 1'b0;
            end
            PH_WA:   begin sa = r_cos; sb = r_uh[r_k]; end
            PH_TA:   begin op = acff_pkg::AU_DIV; sa = r_w; ud = 64'(r_sn); end
            PH_MQC:  begin sa = 64'(r_qc); sb = r_uh[r_k]; end
            PH_FA:   begin sa = r_ka; sb = r_ta; end
            PH_WC:   begin sa = r_cos; sb = r_vh[r_k]; end
            PH_TC:   begin op = acff_pkg::AU_DIV; sa = r_w; ud = 64'(r_sn); end
            PH_MQA:  begin sa = 64'(r_qa); sb = r_vh[r_k]; end
            PH_FC:   begin sa = r_kc; sb = r_tc; end
            default: use_au = 1'b0;
        endcase
        neg         = (op == acff_pkg::AU_MUL) ? (sa[63] ^ sb[63]) : sa[63];
        o_req.start = use_au & ~r_iss;
        o_req.op    = op;
        o_req.a     = (op == acff_pkg::AU_SQRT) ? ua : acff_pkg::mag64(sa);
        o_req.b     = (op == acff_pkg::AU_MUL) ? acff_pkg::mag64(sb) : ud;
        o_req.sh30  = sh30;
    end

    // Sign, shift and clamp the unit's results
    always_comb begin
        root = i_rsp.lo[31:0];
        mr   = acff_pkg::mul_post({i_rsp.hi, i_rsp.lo}, sh30, neg);
        if (i_rsp.dsat) begin
            dr.sat = 1'b1;
            dr.val = neg ? acff_pkg::S64_MIN : acff_pkg::S64_MAX;
        end else begin
            dr = acff_pkg::from_mag(i_rsp.lo, neg);
        end
        fs  = acff_pkg::sub_sat(r_t, mr.val);
        us  = acff_pkg::usq_add(r_s2, r_w);
        fba = acff_pkg::add_sat(r_fa[r_k], r_fc[r_k]);
        fbs = acff_pkg::sub_sat(64'sd0, fba.val);
    end

    // Clamp the nine forces and form the result
    always_comb begin
        o32[0] = acff_pkg::out32(r_fa[0]);
        o32[1] = acff_pkg::out32(r_fa[1]);
        o32[2] = acff_pkg::out32(r_fa[2]);
        o32[3] = acff_pkg::out32(r_fb[0]);
        o32[4] = acff_pkg::out32(r_fb[1]);
        o32[5] = acff_pkg::out32(r_fb[2]);
        o32[6] = acff_pkg::out32(r_fc[0]);
        o32[7] = acff_pkg::out32(r_fc[1]);
        o32[8] = acff_pkg::out32(r_fc[2]);
        any_clamp = 1'b0;
        for (int i = 0; i < 9; i++) any_clamp = any_clamp | o32[i].sat;
        nd.fa_x = o32[0].val;
        nd.fa_y = o32[1].val;
        nd.fa_z = o32[2].val;
        nd.fb_x = o32[3].val;
        nd.fb_y = o32[4].val;
        nd.fb_z = o32[5].val;
        nd.fc_x = o32[6].val;
        nd.fc_y = o32[7].val;
        nd.fc_z = o32[8].val;
        nd.status = (r_sat | any_clamp) ? acff_pkg::ST_SAT : acff_pkg::ST_OK;
        if (r_deg) begin
            nd        = '0;
            nd.status = acff_pkg::ST_DEG;
        end
    end

    assign o_pop    = (r_ph == PH_IDLE) && i_qvalid;
    assign out_free = ~r_ov | ~i_stall;
    assign o_valid  = r_ov;
    assign o_data   = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_IDLE;
            r_k   <= 2'd0;
            r_iss <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            // Load a finished result, or drop the current one after its transfer
            if (r_ph == PH_OUT && out_free) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (o_req.start) r_iss <= 1'b1;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_qvalid) begin
                        r_u[0] <= i_job.ux;
                        r_u[1] <= i_job.uy;
                        r_u[2] <= i_job.uz;
                        r_v[0] <= i_job.vx;
                        r_v[1] <= i_job.vy;
                        r_v[2] <= i_job.vz;
                        r_a2   <= i_job.a2;
                        r_c2   <= i_job.c2;
                        r_qa   <= i_job.qa;
                        r_qc   <= i_job.qc;
                        r_p    <= i_job.p;
                        r_s2   <= 64'd0;
                        r_cos  <= 64'sd0;
                        r_sat  <= 1'b0;
                        r_deg  <= 1'b0;
                        r_k    <= 2'd0;
                        r_ph   <= PH_SQA;
                    end
                end
                PH_S2: begin
                    r_s2  <= us.val;
                    r_sat <= r_sat | us.sat;
                    if (r_k == 2'd2) begin
                        r_k  <= 2'd0;
                        r_ph <= PH_SN;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_ph <= PH_CR0;
                    end
                end
                PH_FB: begin
                    r_fb[r_k] <= fbs.val;
                    r_sat     <= r_sat | fba.sat | fbs.sat;
                    if (r_k == 2'd2) begin
                        r_ph <= PH_OUT;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_ph <= PH_WA;
                    end
                end
                PH_OUT: begin
                    if (out_free) begin
                        r_od <= nd;
                        r_ph <= PH_IDLE;
                    end
                end
                default: begin
                    // Write back a finished unit operation and advance
                    if (i_rsp.done) begin
                        r_iss <= 1'b0;
                        unique case (r_ph)
                            PH_SQA: begin
                                r_ra <= root;
                                r_ph <= PH_SQC;
                            end
                            PH_SQC: begin
                                r_rc <= root;
                                if (r_ra == 32'd0 || root == 32'd0) begin
                                    r_deg <= 1'b1;
                                    r_ph  <= PH_OUT;
                                end else begin
                                    r_ph <= PH_UH;
                                end
                            end
                            PH_UH: begin
                                r_uh[r_k] <= dr.val;
                                r_sat     <= r_sat | dr.sat;
                                r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                                if (r_k == 2'd2) r_ph <= PH_VH;
                            end
                            PH_VH: begin
                                r_vh[r_k] <= dr.val;
                                r_sat     <= r_sat | dr.sat;
                                r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                                if (r_k == 2'd2) r_ph <= PH_COS;
                            end
                            PH_COS: begin
                                r_cos <= r_cos + mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                                if (r_k == 2'd2) r_ph <= PH_CR0;
                            end
                            PH_CR0: begin
                                r_t   <= mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_CR1;
                            end
                            PH_CR1: begin
                                r_w   <= r_t - mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_S2;
                            end
                            PH_SN: begin
                                r_sn <= root;
                                if (root == 32'd0) begin
                                    r_deg <= 1'b1;
                                    r_ph  <= PH_OUT;
                                end else begin
                                    r_ph <= PH_KA;
                                end
                            end
                            PH_KA: begin
                                r_ka  <= dr.val;
                                r_sat <= r_sat | dr.sat;
                                r_ph  <= PH_KC;
                            end
                            PH_KC: begin
                                r_kc  <= dr.val;
                                r_sat <= r_sat | dr.sat;
                                r_k   <= 2'd0;
                                r_ph  <= PH_WA;
                            end
                            PH_WA: begin
                                r_w   <= r_vh[r_k] - mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_TA;
                            end
                            PH_TA: begin
                                r_ta  <= dr.val;
                                r_sat <= r_sat | dr.sat;
                                r_ph  <= PH_MQC;
                            end
                            PH_MQC: begin
                                r_t   <= mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_FA;
                            end
                            PH_FA: begin
                                r_fa[r_k] <= fs.val;
                                r_sat     <= r_sat | mr.sat | fs.sat;
                                r_ph      <= PH_WC;
                            end
                            PH_WC: begin
                                r_w   <= r_uh[r_k] - mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_TC;
                            end
                            PH_TC: begin
                                r_tc  <= dr.val;
                                r_sat <= r_sat | dr.sat;
                                r_ph  <= PH_MQA;
                            end
                            PH_MQA: begin
                                r_t   <= mr.val;
                                r_sat <= r_sat | mr.sat;
                                r_ph  <= PH_FC;
                            end
                            PH_FC: begin
                                r_fc[r_k] <= fs.val;
                                r_sat     <= r_sat | mr.sat | fs.sat;
                                r_ph      <= PH_FB;
                            end
                            default: r_ph <= PH_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/acff_checker.sv =====
// Port-level checks of the angle charge-flux force block, bound to its top level.
// Depends on acff_pkg and angle_charge_flux_force_top.
`default_nettype none
module acff_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire acff_pkg::t_acff_out o_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // Status carries a defined code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == acff_pkg::ST_OK || o_data.status == acff_pkg::ST_DEG
                     || o_data.status == acff_pkg::ST_SAT))
        else $error("undefined status code");

    // Degenerate geometry gives zero forces
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == acff_pkg::ST_DEG |->
            o_data.fa_x == 0 && o_data.fa_y == 0 && o_data.fa_z == 0 &&
            o_data.fb_x == 0 && o_data.fb_y == 0 && o_data.fb_z == 0 &&
            o_data.fc_x == 0 && o_data.fc_y == 0 && o_data.fc_z == 0)
        else $error("degenerate result with nonzero force");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind angle_charge_flux_force_top acff_checker u_acff_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire
